// ===== hw/rtl/qte_pkg.sv =====
`timescale 1ns / 1ps
package qte_pkg;

   // field and datapath widths
   localparam int QW         = 16;
   localparam int PW         = 32;
   localparam int LW         = 36;
   localparam int ZW         = 27;
   localparam int NW         = 33;
   localparam int QBITS      = 30;
   localparam int RW         = 61;
   localparam int ROOTW      = 31;
   localparam int DIV_CELLS  = QBITS;
   localparam int SQRT_CELLS = ROOTW;
   localparam int ATAN_LEN   = 24;
   localparam int AW         = 18;

   localparam logic signed [ZW-1:0] DEG180_Q16 = 27'sd11796480;
   localparam int YAW_LIMIT   = 23040;
   localparam int PITCH_LIMIT = 11520;

   typedef logic signed [LW-1:0] lane_word_type;

   // yaw and roll vectors riding along while pitch is prepared
   typedef struct packed {
      lane_word_type yaw_x;
      lane_word_type yaw_y;
      lane_word_type roll_x;
      lane_word_type roll_y;
      logic          zero;
   } side_type;

   typedef struct packed {
      logic [NW-1:0]    rem;
      logic [NW-1:0]    norm;
      logic [QBITS-1:0] quo;
      logic             sat;
      logic             neg;
      side_type         side;
   } div_type;

   typedef struct packed {
      logic [RW-1:0]    rem;
      logic [ROOTW-1:0] root;
      lane_word_type    s;
      side_type         side;
   } sqrt_type;

   typedef struct packed {
      lane_word_type          x;
      lane_word_type          y;
      logic signed [ZW-1:0]   z;
      logic                   nil;
   } lane_type;

   typedef struct packed {
      lane_type yaw;
      lane_type pitch;
      lane_type roll;
      logic     zero;
   } cord_type;

   // atan(2^-k) in degrees, Q16
   function automatic logic signed [ZW-1:0] atan_q16(input int k);
      logic signed [ZW-1:0] r;
      case (k)
         0:  r = 27'sd2949120;
         1:  r = 27'sd1740967;
         2:  r = 27'sd919879;
         3:  r = 27'sd466945;
         4:  r = 27'sd234379;
         5:  r = 27'sd117304;
         6:  r = 27'sd58666;
         7:  r = 27'sd29335;
         8:  r = 27'sd14668;
         9:  r = 27'sd7334;
         10: r = 27'sd3667;
         11: r = 27'sd1833;
         12: r = 27'sd917;
         13: r = 27'sd458;
         14: r = 27'sd229;
         15: r = 27'sd115;
         16: r = 27'sd57;
         17: r = 27'sd29;
         18: r = 27'sd14;
         19: r = 27'sd7;
         20: r = 27'sd4;
         21: r = 27'sd2;
         22: r = 27'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/qte_if.sv =====
`timescale 1ns / 1ps
interface qte_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] quat_i;
   logic signed [15:0] quat_j;
   logic signed [15:0] quat_k;
   logic signed [15:0] quat_real;
   modport source (output valid, quat_i, quat_j, quat_k, quat_real, input ready);
   modport sink   (input valid, quat_i, quat_j, quat_k, quat_real, output ready);
endinterface

interface qte_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] yaw_angle;
   logic signed [14:0] pitch_angle;
   logic signed [15:0] roll_angle;
   logic               zero_norm;
   modport source (output valid, yaw_angle, pitch_angle, roll_angle, zero_norm, input ready);
   modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, zero_norm, output ready);
endinterface

// ===== hw/rtl/quaternion_to_euler_angles.sv =====
`timescale 1ns / 1ps
// Throughput: one word per cycle unless a held rsp word stalls the chain;
// the chain of divider, square root and CORDIC cells holds one word in
// each cell and all cells advance together.
// Reset (synchronous, active high) clears every valid bit and holds req ready
// low; data registers keep their contents.
module quaternion_to_euler_angles #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic           clock,
   input  logic           reset,
   qte_req_if.sink        req_chan,
   qte_rsp_if.source      rsp_chan
);
   import qte_pkg::*;

   logic en;

   // product stage
   logic                 p_vld_ff;
   logic signed [PW-1:0] p_ii_ff, p_jj_ff, p_kk_ff, p_rr_ff;
   logic signed [PW-1:0] p_ij_ff, p_kr_ff, p_jk_ff, p_ir_ff, p_ik_ff, p_jr_ff;

   // sum stage
   logic          s_vld_ff;
   div_type       s_ff;
   div_type       s_in;
   lane_word_type norm_w, num_w, mag_w;

   // cell chains
   logic     div_vld [0:DIV_CELLS];
   div_type  div_bus [0:DIV_CELLS];
   logic     sq_vld  [0:SQRT_CELLS];
   sqrt_type sq_bus  [0:SQRT_CELLS];
   logic     cr_vld  [0:CORDIC_STEPS];
   cord_type cr_bus  [0:CORDIC_STEPS];

   // ratio square stage
   logic                  q_vld_ff;
   logic [ROOTW-1:0]      q_ff;
   logic [2*ROOTW-1:0]    qsq_ff;
   logic                  q_neg_ff;
   side_type              q_side_ff;
   logic [ROOTW-1:0]      q_in;

   // radicand stage
   logic     r_vld_ff;
   sqrt_type r_ff;

   // pre-rotation stage
   logic     pr_vld_ff;
   cord_type pr_ff;

   // output register
   logic                 rsp_vld_ff;
   logic signed [15:0]   yaw_ff;
   logic signed [14:0]   pitch_ff;
   logic signed [15:0]   roll_ff;
   logic                 zero_ff;

   assign en             = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready = en && !reset;

   // fold x into the right half plane
   function automatic lane_type prerot(input lane_word_type y, input lane_word_type x);
      lane_type r;
      r.nil = (x == '0) && (y == '0);
      r.x   = x;
      r.y   = y;
      r.z   = '0;
      if (x < 0) begin
         r.z = (y >= 0) ? DEG180_Q16 : -DEG180_Q16;
         r.x = -x;
         r.y = -y;
      end
      return r;
   endfunction

   // round Q16 degrees to 1/128 degree and clamp, zero for a nil vector
   function automatic logic signed [AW-1:0] finish(input lane_type a, input int lim);
      logic signed [ZW-1:0] t;
      logic signed [AW-1:0] r;
      t = (a.z + ZW'(256)) >>> 9;
      r = AW'(t);
      if (a.nil) begin
         r = '0;
      end else if (r > lim) begin
         r = AW'(lim);
      end else if (r < -lim) begin
         r = AW'(-lim);
      end
      return r;
   endfunction

   // form the ten products
   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (en) begin
         p_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ii_ff <= req_chan.quat_i * req_chan.quat_i;
         p_jj_ff <= req_chan.quat_j * req_chan.quat_j;
         p_kk_ff <= req_chan.quat_k * req_chan.quat_k;
         p_rr_ff <= req_chan.quat_real * req_chan.quat_real;
         p_ij_ff <= req_chan.quat_i * req_chan.quat_j;
         p_kr_ff <= req_chan.quat_k * req_chan.quat_real;
         p_jk_ff <= req_chan.quat_j * req_chan.quat_k;
         p_ir_ff <= req_chan.quat_i * req_chan.quat_real;
         p_ik_ff <= req_chan.quat_i * req_chan.quat_k;
         p_jr_ff <= req_chan.quat_j * req_chan.quat_real;
      end
   end

   // build the vectors, the norm and the pitch numerator
   always_comb begin
      norm_w = LW'(p_ii_ff) + LW'(p_jj_ff) + LW'(p_kk_ff) + LW'(p_rr_ff);
      num_w  = (LW'(p_jr_ff) - LW'(p_ik_ff)) <<< 1;
      mag_w  = (num_w < 0) ? -num_w : num_w;
      s_in.side.yaw_y  = (LW'(p_ij_ff) + LW'(p_kr_ff)) <<< 1;
      s_in.side.yaw_x  = LW'(p_ii_ff) - LW'(p_jj_ff) - LW'(p_kk_ff) + LW'(p_rr_ff);
      s_in.side.roll_y = (LW'(p_jk_ff) + LW'(p_ir_ff)) <<< 1;
      s_in.side.roll_x = LW'(p_kk_ff) + LW'(p_rr_ff) - LW'(p_ii_ff) - LW'(p_jj_ff);
      s_in.side.zero   = norm_w == '0;
      s_in.rem  = NW'(mag_w);
      s_in.norm = NW'(norm_w);
      s_in.quo  = '0;
      s_in.sat  = mag_w >= norm_w;
      s_in.neg  = num_w < 0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
      end else if (en) begin
         s_vld_ff <= p_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff <= s_in;
      end
   end

   // divider chain
   assign div_vld[0] = s_vld_ff;
   assign div_bus[0] = s_ff;

   for (genvar n = 0; n < DIV_CELLS; n++) begin : g_div
      qte_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_vld   (div_vld[n]),
         .in_data  (div_bus[n]),
         .out_vld  (div_vld[n+1]),
         .out_data (div_bus[n+1])
      );
   end

   // saturate the ratio and square it
   assign q_in = div_bus[DIV_CELLS].sat ? (ROOTW'(1) << QBITS)
                                        : {1'b0, div_bus[DIV_CELLS].quo};

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff <= 1'b0;
      end else if (en) begin
         q_vld_ff <= div_vld[DIV_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff      <= q_in;
         qsq_ff    <= q_in * q_in;
         q_neg_ff  <= div_bus[DIV_CELLS].neg;
         q_side_ff <= div_bus[DIV_CELLS].side;
      end
   end

   // radicand 1 - s^2 and signed sine
   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld_ff <= 1'b0;
      end else if (en) begin
         r_vld_ff <= q_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff.rem  <= RW'((2*ROOTW)'(1) << (2*QBITS)) - RW'(qsq_ff);
         r_ff.root <= '0;
         r_ff.s    <= q_neg_ff ? -LW'(q_ff) : LW'(q_ff);
         r_ff.side <= q_side_ff;
      end
   end

   // square root chain, one root bit per cell from the top
   assign sq_vld[0] = r_vld_ff;
   assign sq_bus[0] = r_ff;

   for (genvar n = 0; n < SQRT_CELLS; n++) begin : g_sqrt
      qte_sqrt_cell #(.BIT(SQRT_CELLS - 1 - n)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_vld   (sq_vld[n]),
         .in_data  (sq_bus[n]),
         .out_vld  (sq_vld[n+1]),
         .out_data (sq_bus[n+1])
      );
   end

   // pre-rotate all three vectors
   always_ff @(posedge clock) begin
      if (reset) begin
         pr_vld_ff <= 1'b0;
      end else if (en) begin
         pr_vld_ff <= sq_vld[SQRT_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pr_ff.yaw   <= prerot(sq_bus[SQRT_CELLS].side.yaw_y, sq_bus[SQRT_CELLS].side.yaw_x);
         pr_ff.roll  <= prerot(sq_bus[SQRT_CELLS].side.roll_y,
                               sq_bus[SQRT_CELLS].side.roll_x);
         pr_ff.pitch <= prerot(sq_bus[SQRT_CELLS].s, LW'(sq_bus[SQRT_CELLS].root));
         pr_ff.zero  <= sq_bus[SQRT_CELLS].side.zero;
      end
   end

   // CORDIC chain
   assign cr_vld[0] = pr_vld_ff;
   assign cr_bus[0] = pr_ff;

   for (genvar n = 0; n < CORDIC_STEPS; n++) begin : g_cordic
      qte_cordic_cell #(.STEP(n)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_vld   (cr_vld[n]),
         .in_data  (cr_bus[n]),
         .out_vld  (cr_vld[n+1]),
         .out_data (cr_bus[n+1])
      );
   end

   // output register: round, clamp, blank on zero quaternion
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= cr_vld[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff <= cr_bus[CORDIC_STEPS].zero;
         if (cr_bus[CORDIC_STEPS].zero) begin
            yaw_ff   <= '0;
            pitch_ff <= '0;
            roll_ff  <= '0;
         end else begin
            yaw_ff   <= 16'(finish(cr_bus[CORDIC_STEPS].yaw, YAW_LIMIT));
            pitch_ff <= 15'(finish(cr_bus[CORDIC_STEPS].pitch, PITCH_LIMIT));
            roll_ff  <= 16'(finish(cr_bus[CORDIC_STEPS].roll, YAW_LIMIT));
         end
      end
   end

   assign rsp_chan.valid       = rsp_vld_ff;
   assign rsp_chan.yaw_angle   = yaw_ff;
   assign rsp_chan.pitch_angle = pitch_ff;
   assign rsp_chan.roll_angle  = roll_ff;
   assign rsp_chan.zero_norm   = zero_ff;

`ifndef SYNTHESIS
   a_zero_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.zero_norm |->
         (rsp_chan.yaw_angle == 0) && (rsp_chan.pitch_angle == 0) &&
         (rsp_chan.roll_angle == 0))
      else $error("zero quaternion gave nonzero angles");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         (rsp_chan.yaw_angle >= -23040) && (rsp_chan.yaw_angle <= 23040) &&
         (rsp_chan.roll_angle >= -23040) && (rsp_chan.roll_angle <= 23040) &&
         (rsp_chan.pitch_angle >= -11520) && (rsp_chan.pitch_angle <= 11520))
      else $error("angle out of range");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> p_vld_ff)
      else $error("accepted word not captured");
`endif
endmodule

// ===== hw/rtl/qte_div_cell.sv =====
`timescale 1ns / 1ps
module qte_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_vld,
   input  qte_pkg::div_type in_data,
   output logic             out_vld,
   output qte_pkg::div_type out_data
);
   import qte_pkg::*;

   logic          vld_ff;
   div_type       data_ff;
   div_type       data_in;
   logic [NW:0]   dbl;
   logic          take;

   // one restoring quotient bit
   always_comb begin
      dbl     = {in_data.rem, 1'b0};
      take    = dbl >= {1'b0, in_data.norm};
      data_in = in_data;
      if (take) begin
         data_in.rem = NW'(dbl - {1'b0, in_data.norm});
      end else begin
         data_in.rem = dbl[NW-1:0];
      end
      data_in.quo = {in_data.quo[QBITS-2:0], take};
   end

   // advance valid
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_data = data_ff;
endmodule

// ===== hw/rtl/qte_sqrt_cell.sv =====
`timescale 1ns / 1ps
module qte_sqrt_cell #(
   parameter int BIT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  qte_pkg::sqrt_type in_data,
   output logic              out_vld,
   output qte_pkg::sqrt_type out_data
);
   import qte_pkg::*;

   localparam int TW = RW + 1;

   logic          vld_ff;
   sqrt_type      data_ff;
   sqrt_type      data_in;
   logic [TW-1:0] trial;
   logic          take;

   // one root bit: try (root << (b+1)) + 4^b against the remainder
   always_comb begin
      trial   = (TW'(in_data.root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
      take    = {1'b0, in_data.rem} >= trial;
      data_in = in_data;
      if (take) begin
         data_in.rem  = RW'({1'b0, in_data.rem} - trial);
         data_in.root = in_data.root | (ROOTW'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_data = data_ff;
endmodule

// ===== hw/rtl/qte_cordic_cell.sv =====
`timescale 1ns / 1ps
module qte_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  qte_pkg::cord_type in_data,
   output logic              out_vld,
   output qte_pkg::cord_type out_data
);
   import qte_pkg::*;

   logic     vld_ff;
   cord_type data_ff;
   cord_type data_in;

   // one vectoring micro-rotation, shifts floor toward minus infinity
   function automatic lane_type rotate(input lane_type a);
      lane_type      r;
      lane_word_type xs;
      lane_word_type ys;
      xs = a.x >>> STEP;
      ys = a.y >>> STEP;
      r  = a;
      if (a.y > 0) begin
         r.x = a.x + ys;
         r.y = a.y - xs;
         r.z = a.z + atan_q16(STEP);
      end else begin
         r.x = a.x - ys;
         r.y = a.y + xs;
         r.z = a.z - atan_q16(STEP);
      end
      return r;
   endfunction

   always_comb begin
      data_in       = in_data;
      data_in.yaw   = rotate(in_data.yaw);
      data_in.pitch = rotate(in_data.pitch);
      data_in.roll  = rotate(in_data.roll);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_data = data_ff;
endmodule
